@@ rtl/coo_spmv_pkg.sv @@
// Shared types and constants for the coordinate-list sparse matrix-vector unit.
// No dependencies.
package coo_spmv_pkg;

	localparam int MAX_ENTRIES_DEF = 256;
	localparam int MAX_DIM_DEF     = 64;

	localparam logic [1:0] REQ_ADD  = 2'd0;
	localparam logic [1:0] REQ_LOAD = 2'd1;
	localparam logic [1:0] REQ_MUL  = 2'd2;
	localparam logic [1:0] REQ_BAD  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO     = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_MISMATCH = 2'd3;

	// Request handed from the front part to the back part.
	typedef struct packed {
		logic [1:0]  req_type;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [15:0] value;
		logic [5:0]  x_index;
		logic [15:0] x_value;
		logic [6:0]  x_length;
	} coo_req_t;

	// One result item.
	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  out_row;
		logic [31:0] y_value;
		logic        last;
	} coo_res_t;

	localparam int REQ_W = $bits(coo_req_t);
	localparam int RES_W = $bits(coo_res_t);

endpackage

@@ rtl/coo_spmv_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module coo_spmv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/coo_spmv_fifo.sv @@
// Small register queue between the front and back parts, also used as result buffer.
// No dependencies.
module coo_spmv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] out_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             push, pop;

	assign in_stall  = (cnt_q == (AW+1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = buf_q[rp_q];
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= in_data;
		end
	end

endmodule

@@ rtl/coo_spmv_back.sv @@
// Back part: entry table, vector, accumulators and the sequencer that runs requests.
// Depends on coo_spmv_pkg and coo_spmv_ram.
module coo_spmv_back #(
	parameter int MAX_ENTRIES = coo_spmv_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_DIM     = coo_spmv_pkg::MAX_DIM_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  coo_spmv_pkg::coo_req_t req,
	output logic                   res_valid,
	input  logic                   res_stall,
	output coo_spmv_pkg::coo_res_t res
);

	localparam int EA = $clog2(MAX_ENTRIES);
	localparam int EC = EA + 1;
	localparam int DA = $clog2(MAX_DIM);
	localparam int DC = DA + 1;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SRCH   = 9'b000000010,
		S_SCHK   = 9'b000000100,
		S_CLR    = 9'b000001000,
		S_MRD    = 9'b000010000,
		S_MMUL   = 9'b000100000,
		S_MACC   = 9'b001000000,
		S_ORD    = 9'b010000000,
		S_OUT    = 9'b100000000
	} st_t;

	st_t st_q;
	coo_spmv_pkg::coo_req_t r_q;
	logic [EC-1:0] cnt_q, k_q;
	logic [DC-1:0] lrow_q, lcol_q;
	logic [DA:0]   oi_q;
	logic [MAX_DIM-1:0] xv_q;  // vector element written since reset

	// Entry table memories.
	logic          e_we;
	logic [EA-1:0] e_wa, e_ra;
	logic [5:0]    erow_rd, ecol_rd;
	logic [15:0]   eval_rd;
	logic [5:0]    e_wrow, e_wcol;

	coo_spmv_ram #(.WIDTH(6), .DEPTH(MAX_ENTRIES)) u_erow (
		.clk(clk), .we(e_we && (st_q == S_IDLE || st_q == S_SCHK)), .waddr(e_wa),
		.wdata(e_wrow), .raddr(e_ra), .rdata(erow_rd));
	coo_spmv_ram #(.WIDTH(6), .DEPTH(MAX_ENTRIES)) u_ecol (
		.clk(clk), .we(e_we && (st_q == S_IDLE || st_q == S_SCHK)), .waddr(e_wa),
		.wdata(e_wcol), .raddr(e_ra), .rdata(ecol_rd));
	coo_spmv_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_eval (
		.clk(clk), .we(e_we), .waddr(e_wa),
		.wdata(r_q.value), .raddr(e_ra), .rdata(eval_rd));

	// Vector memory; unwritten elements read as zero through xv_q.
	logic          x_we;
	logic [DA-1:0] x_ra;
	logic [15:0]   x_rd;
	coo_spmv_ram #(.WIDTH(16), .DEPTH(MAX_DIM)) u_x (
		.clk(clk), .we(x_we), .waddr(r_q.x_index[DA-1:0]),
		.wdata(r_q.x_value), .raddr(x_ra), .rdata(x_rd));

	// Accumulator memory.
	logic          a_we;
	logic [DA-1:0] a_wa, a_ra;
	logic [31:0]   a_wd, a_rd;
	coo_spmv_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_acc (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));

	logic [5:0]    row_s, col_s;
	logic [15:0]   val_s;
	logic signed [31:0] prod_s;
	logic [DA-1:0] prow_s;
	logic [EC-1:0] hit_q;      // matching entry index, valid when hit_v_q is set
	logic          hit_v_q;
	logic          in_rng;
	logic signed [32:0] sum;
	logic [31:0]   sat;

	assign in_rng = (MAX_DIM >= 64) ||
		((r_q.row < 6'(MAX_DIM)) && (r_q.col < 6'(MAX_DIM)));
	assign req_stall = (st_q != S_IDLE) || res_valid;

	// Saturating accumulate of the registered product.
	assign sum = $signed({a_rd[31], a_rd}) + $signed({prod_s[31], prod_s});
	always_comb begin
		if (sum[32] != sum[31]) begin
			sat = sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		end else begin
			sat = sum[31:0];
		end
	end

	// Memory port steering.
	always_comb begin
		e_we   = 1'b0;
		e_wa   = cnt_q[EA-1:0];
		e_wrow = r_q.row;
		e_wcol = r_q.col;
		e_ra   = k_q[EA-1:0];
		x_we   = 1'b0;
		x_ra   = ecol_rd[DA-1:0];
		a_we   = 1'b0;
		a_wa   = oi_q[DA-1:0];
		a_wd   = '0;
		a_ra   = erow_rd[DA-1:0];
		unique case (st_q)
			S_IDLE: begin
			end
			S_SCHK: begin
				if (hit_v_q) begin
					e_we = 1'b1;
					e_wa = hit_q[EA-1:0];
				end else if (cnt_q != EC'(MAX_ENTRIES)) begin
					e_we = 1'b1;
				end
			end
			S_CLR: begin
				a_we = 1'b1;
			end
			S_MACC: begin
				// Fetch the next entry so its data is ready in S_MRD.
				e_ra = k_q[EA-1:0] + EA'(1);
				a_we = 1'b1;
				a_wa = prow_s;
				a_wd = sat;
				a_ra = prow_s;
			end
			S_ORD, S_OUT: begin
				a_ra = oi_q[DA-1:0];
			end
			default: begin
			end
		endcase
		if (st_q == S_MMUL) begin
			a_ra = row_s[DA-1:0];
		end
		if (st_q == S_SRCH && r_q.req_type == coo_spmv_pkg::REQ_LOAD) begin
			x_we = 1'b1;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			cnt_q     <= '0;
			lrow_q    <= '0;
			lcol_q    <= '0;
			xv_q      <= '0;
			res_valid <= 1'b0;
			k_q       <= '0;
			oi_q      <= '0;
			hit_v_q   <= 1'b0;
		end else begin
			// The output state handles its own handshake.
			if (res_valid && !res_stall && st_q != S_OUT) begin
				res_valid <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (req_valid && !req_stall) begin
						r_q     <= req;
						k_q     <= '0;
						hit_v_q <= 1'b0;
						res.out_row <= '0;
						res.y_value <= '0;
						res.last    <= 1'b1;
						priority case (req.req_type)
							coo_spmv_pkg::REQ_ADD: begin
								st_q <= S_SRCH;
							end
							coo_spmv_pkg::REQ_LOAD: begin
								if (MAX_DIM < 64 && req.x_index >= 6'(MAX_DIM)) begin
									res.status <= coo_spmv_pkg::ST_MISMATCH;
									res_valid  <= 1'b1;
								end else begin
									st_q <= S_SRCH;
								end
							end
							coo_spmv_pkg::REQ_MUL: begin
								if (req.x_length != 7'(lcol_q)) begin
									res.status <= coo_spmv_pkg::ST_MISMATCH;
									res_valid  <= 1'b1;
								end else begin
									oi_q <= '0;
									st_q <= S_CLR;
								end
							end
							default: begin
								res.status <= coo_spmv_pkg::ST_MISMATCH;
								res_valid  <= 1'b1;
							end
						endcase
					end
				end
				// Duplicate search: one entry per cycle, read data lagging the address by one register.
				S_SRCH: begin
					if (r_q.req_type == coo_spmv_pkg::REQ_LOAD) begin
						xv_q[r_q.x_index[DA-1:0]] <= 1'b1;
						res.status <= coo_spmv_pkg::ST_OK;
						res_valid  <= 1'b1;
						st_q <= S_IDLE;
					end else if (r_q.value == '0) begin
						res.status <= coo_spmv_pkg::ST_ZERO;
						res_valid  <= 1'b1;
						st_q <= S_IDLE;
					end else if (!in_rng) begin
						res.status <= coo_spmv_pkg::ST_MISMATCH;
						res_valid  <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						if (k_q != '0 && !hit_v_q && erow_rd == r_q.row && ecol_rd == r_q.col) begin
							hit_v_q <= 1'b1;
							hit_q   <= k_q - 1'b1;
						end
						if (k_q >= cnt_q || hit_v_q) begin
							st_q <= S_SCHK;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_SCHK: begin
					res_valid <= 1'b1;
					st_q      <= S_IDLE;
					if (hit_v_q) begin
						res.status <= coo_spmv_pkg::ST_OK;
					end else if (cnt_q == EC'(MAX_ENTRIES)) begin
						res.status <= coo_spmv_pkg::ST_FULL;
					end else begin
						res.status <= coo_spmv_pkg::ST_OK;
						cnt_q <= cnt_q + 1'b1;
						if (DC'({1'b0, r_q.row}) + 1'b1 > lrow_q) begin
							lrow_q <= DC'({1'b0, r_q.row}) + 1'b1;
						end
						if (DC'({1'b0, r_q.col}) + 1'b1 > lcol_q) begin
							lcol_q <= DC'({1'b0, r_q.col}) + 1'b1;
						end
					end
				end
				// Clear accumulators, one per cycle.
				S_CLR: begin
					if (oi_q == (DA+1)'(MAX_DIM-1)) begin
						k_q  <= '0;
						st_q <= (cnt_q == '0) ? S_ORD : S_MRD;
						oi_q <= '0;
					end else begin
						oi_q <= oi_q + 1'b1;
					end
				end
				// Entry data for k_q is valid now; x and accumulator reads follow.
				S_MRD: begin
					st_q <= S_MMUL;
				end
				// Entry in hand, x and accumulator read now; take the product.
				S_MMUL: begin
					st_q <= S_MACC;
				end
				S_MACC: begin
					if (k_q + 1'b1 == cnt_q) begin
						st_q <= S_ORD;
						oi_q <= '0;
					end else begin
						k_q  <= k_q + 1'b1;
						st_q <= S_MRD;
					end
				end
				S_ORD: begin
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (!res_valid || !res_stall) begin
						res_valid      <= 1'b1;
						res.status     <= coo_spmv_pkg::ST_OK;
						res.out_row    <= 6'(oi_q);
						res.y_value    <= (lrow_q == '0) ? '0 : a_rd;
						res.last       <= (lrow_q == '0) ||
							(DC'(oi_q) + 1'b1 == lrow_q);
						if (lrow_q == '0 || DC'(oi_q) + 1'b1 == lrow_q) begin
							st_q <= S_IDLE;
						end else begin
							oi_q <= oi_q + 1'b1;
							st_q <= S_ORD;
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// Multiply datapath: latch entry, then registered product.
	always_ff @(posedge clk) begin
		if (st_q == S_MRD) begin
			row_s <= erow_rd;
			col_s <= ecol_rd;
			val_s <= eval_rd;
		end
		if (st_q == S_MMUL) begin
			prow_s <= row_s[DA-1:0];
		end
	end

	// x read address was col during S_MRD; data valid in S_MMUL.
	logic signed [31:0] prod_c;
	assign prod_c = $signed(val_s) * $signed(xv_q[col_s[DA-1:0]] ? x_rd : 16'd0);
	always_ff @(posedge clk) begin
		if (st_q == S_MMUL) begin
			prod_s <= prod_c;
		end
	end

endmodule

@@ rtl/coo_spmv_front.sv @@
// Front part: accepts requests from the port and queues them for the back part.
// Depends on coo_spmv_pkg and coo_spmv_fifo.
module coo_spmv_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  coo_spmv_pkg::coo_req_t in_req,
	output logic                   q_valid,
	input  logic                   q_stall,
	output coo_spmv_pkg::coo_req_t q_req
);

	coo_spmv_pkg::coo_req_t cls;

	// Classify: an unknown request code is normalized so the back part sees a clean code.
	always_comb begin
		cls = in_req;
		if (in_req.req_type == coo_spmv_pkg::REQ_BAD) begin
			cls.req_type = coo_spmv_pkg::REQ_BAD;
		end
	end

	coo_spmv_fifo #(.WIDTH(coo_spmv_pkg::REQ_W), .DEPTH(2)) u_q (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(cls),
		.out_valid(q_valid), .out_stall(q_stall), .out_data(q_req));

endmodule

@@ rtl/coo_sparse_matrix_vector_multiply_unit.sv @@
// Coordinate-list sparse matrix times vector unit.
// Add: a duplicate search over the table, one entry per cycle, then the insert or overwrite.
// Load writes x. Multiply: clear MAX_DIM accumulators, read/multiply/add each entry, emit rows.
// One request at a time in the back part; a two-deep queue and a result buffer decouple ports.
// Reset (arst_n low) empties the table, marks the vector all zero and idles the sequencer.
// Depends on coo_spmv_pkg, coo_spmv_front, coo_spmv_back, coo_spmv_fifo, coo_spmv_ram.
module coo_sparse_matrix_vector_multiply_unit #(
	parameter int MAX_ENTRIES = coo_spmv_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_DIM     = coo_spmv_pkg::MAX_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [5:0]  row,
	input  logic [5:0]  col,
	input  logic signed [15:0] value,
	input  logic [5:0]  x_index,
	input  logic signed [15:0] x_value,
	input  logic [6:0]  x_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [5:0]  out_row,
	output logic signed [31:0] y_value,
	output logic        last
);

	coo_spmv_pkg::coo_req_t in_req, q_req;
	coo_spmv_pkg::coo_res_t res, ores;
	logic q_valid, q_stall, res_valid, res_stall;

	assign in_req = '{req_type: req_type, row: row, col: col, value: value,
		x_index: x_index, x_value: x_value, x_length: x_length};

	coo_spmv_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
		.q_valid(q_valid), .q_stall(q_stall), .q_req(q_req));

	coo_spmv_back #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_DIM(MAX_DIM)) u_back (
		.clk(clk), .arst_n(arst_n),
		.req_valid(q_valid), .req_stall(q_stall), .req(q_req),
		.res_valid(res_valid), .res_stall(res_stall), .res(res));

	// Result buffer so the sequencer keeps running while the consumer stalls.
	coo_spmv_fifo #(.WIDTH(coo_spmv_pkg::RES_W), .DEPTH(2)) u_res (
		.clk(clk), .arst_n(arst_n),
		.in_valid(res_valid), .in_stall(res_stall), .in_data(res),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(ores));

	assign status  = ores.status;
	assign out_row = ores.out_row;
	assign y_value = ores.y_value;
	assign last    = ores.last;

endmodule

@@ tb/coo_sparse_matrix_vector_multiply_unit_test.sv @@
// Self-checking testbench for coo_sparse_matrix_vector_multiply_unit.
// Drives add, load and multiply requests with random idling on both sides and checks every
// result against a built-in predictor. Depends on coo_spmv_pkg and the unit's RTL.
module coo_sparse_matrix_vector_multiply_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 256;
	localparam int VEC_DEPTH   = 64;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int QUIET_TAIL  = 40;
	localparam int LONG_HOLD   = 3000;

	typedef struct {
		logic [1:0]         rt;
		logic [5:0]         r;
		logic [5:0]         c;
		logic signed [15:0] v;
		logic [5:0]         xi;
		logic signed [15:0] xv;
		logic [6:0]         xl;
		bit                 drain;
	} spmv_req_t;

	typedef struct {
		logic [1:0]         st;
		logic [5:0]         orow;
		logic signed [31:0] y;
		logic               lst;
	} y_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = '0;
	logic [5:0] row = '0;
	logic [5:0] col = '0;
	logic signed [15:0] value = '0;
	logic [5:0] x_index = '0;
	logic signed [15:0] x_value = '0;
	logic [6:0] x_length = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [5:0] out_row;
	logic signed [31:0] y_value;
	logic last;

	coo_sparse_matrix_vector_multiply_unit uut (.*);

	always #5 clk = ~clk;

	spmv_req_t pending_reqs[$];
	y_item_t   expected_y[$];
	spmv_req_t cur_req;
	bit        took;
	int        errors;
	int        cycles;
	int        accepted;

	// Predictor state: the coordinate table, the vector and the accumulators.
	logic [5:0]         tbl_row[TABLE_DEPTH];
	logic [5:0]         tbl_col[TABLE_DEPTH];
	logic signed [15:0] tbl_val[TABLE_DEPTH];
	int                 tbl_count;
	int                 rows_used;
	int                 cols_used;
	logic signed [15:0] x_vec[VEC_DEPTH];
	logic signed [31:0] y_acc[VEC_DEPTH];

	// Mirror kept by the stimulus generator, so multiplies can carry a matching length.
	bit gen_seen[VEC_DEPTH][VEC_DEPTH];
	int gen_count;
	int gen_cols;

	function automatic void expect_y(logic [1:0] st, logic [5:0] orow, logic signed [31:0] y,
			logic lst);
		y_item_t e;
		e.st = st;
		e.orow = orow;
		e.y = y;
		e.lst = lst;
		expected_y.push_back(e);
	endfunction

	// Works out the results of one accepted request and updates the predictor state.
	function automatic void predict_products(spmv_req_t q);
		int hit;
		longint s;
		case (q.rt)
			coo_spmv_pkg::REQ_ADD: begin
				if (q.v == 0) begin
					expect_y(coo_spmv_pkg::ST_ZERO, '0, '0, 1'b1);
				end else begin
					hit = -1;
					for (int k = 0; k < tbl_count; k++)
						if (tbl_row[k] == q.r && tbl_col[k] == q.c) hit = k;
					if (hit >= 0) begin
						tbl_val[hit] = q.v;
						expect_y(coo_spmv_pkg::ST_OK, '0, '0, 1'b1);
					end else if (tbl_count >= TABLE_DEPTH) begin
						expect_y(coo_spmv_pkg::ST_FULL, '0, '0, 1'b1);
					end else begin
						tbl_row[tbl_count] = q.r;
						tbl_col[tbl_count] = q.c;
						tbl_val[tbl_count] = q.v;
						tbl_count++;
						if (int'(q.r) + 1 > rows_used) rows_used = int'(q.r) + 1;
						if (int'(q.c) + 1 > cols_used) cols_used = int'(q.c) + 1;
						expect_y(coo_spmv_pkg::ST_OK, '0, '0, 1'b1);
					end
				end
			end
			coo_spmv_pkg::REQ_LOAD: begin
				x_vec[q.xi] = q.xv;
				expect_y(coo_spmv_pkg::ST_OK, '0, '0, 1'b1);
			end
			coo_spmv_pkg::REQ_MUL: begin
				if (int'(q.xl) != cols_used) begin
					expect_y(coo_spmv_pkg::ST_MISMATCH, '0, '0, 1'b1);
				end else begin
					for (int k = 0; k < VEC_DEPTH; k++) y_acc[k] = '0;
					// Saturating accumulation in storage order.
					for (int k = 0; k < tbl_count; k++) begin
						s = longint'(y_acc[tbl_row[k]]) +
							longint'(tbl_val[k]) * longint'(x_vec[tbl_col[k]]);
						if (s > 64'sh7FFFFFFF) s = 64'sh7FFFFFFF;
						if (s < -64'sh80000000) s = -64'sh80000000;
						y_acc[tbl_row[k]] = s[31:0];
					end
					if (rows_used == 0) begin
						expect_y(coo_spmv_pkg::ST_OK, '0, '0, 1'b1);
					end else begin
						for (int k = 0; k < rows_used; k++)
							expect_y(coo_spmv_pkg::ST_OK, k[5:0], y_acc[k], k == rows_used - 1);
					end
				end
			end
			default: expect_y(coo_spmv_pkg::ST_MISMATCH, '0, '0, 1'b1);
		endcase
	endfunction

	function automatic void queue_req(logic [1:0] rt, logic [5:0] r, logic [5:0] c,
			logic signed [15:0] v, logic [5:0] xi, logic signed [15:0] xv, logic [6:0] xl,
			bit drain = 0);
		spmv_req_t q;
		q = '{rt, r, c, v, xi, xv, xl, drain};
		if (rt == coo_spmv_pkg::REQ_ADD && v != 0 && !gen_seen[r][c] &&
				gen_count < TABLE_DEPTH) begin
			gen_seen[r][c] = 1;
			gen_count++;
			if (int'(c) + 1 > gen_cols) gen_cols = int'(c) + 1;
		end
		pending_reqs.push_back(q);
	endfunction

	function automatic logic signed [15:0] rand_q88();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return -16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Result check and request capture at the rising edge.
	always @(posedge clk) begin
		y_item_t e;
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
			took = in_valid && !in_stall;
			if (took) begin
				predict_products(cur_req);
				accepted++;
			end
			if (out_valid && !out_stall) begin
				if (expected_y.size() == 0) begin
					$error("unexpected result: status %0d out_row %0d y_value %0d last %0d",
						status, out_row, y_value, last);
					errors++;
				end else begin
					e = expected_y.pop_front();
					if (status !== e.st) begin
						$error("status: expected %0d, got %0d", e.st, status);
						errors++;
					end
					if (out_row !== e.orow) begin
						$error("out_row: expected %0d, got %0d", e.orow, out_row);
						errors++;
					end
					if (y_value !== e.y) begin
						$error("y_value: expected %0d, got %0d", e.y, y_value);
						errors++;
					end
					if (last !== e.lst) begin
						$error("last: expected %0d, got %0d", e.lst, last);
						errors++;
					end
				end
			end
		end
	end

	// Request driver: presents the next queued request at the falling edge.
	int gap_left;
	always @(negedge clk) begin
		if (arst_n && (!in_valid || took)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() == 0 ||
					(pending_reqs[0].drain && expected_y.size() != 0)) begin
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
				gap_left = $urandom_range(1, 14) - 1;
				in_valid <= 1'b0;
			end else begin
				cur_req = pending_reqs.pop_front();
				req_type <= cur_req.rt;
				row <= cur_req.r;
				col <= cur_req.c;
				value <= cur_req.v;
				x_index <= cur_req.xi;
				x_value <= cur_req.xv;
				x_length <= cur_req.xl;
				in_valid <= 1'b1;
			end
		end
	end

	// Result receiver: random stall bursts plus one long hold-off.
	int stall_left;
	int hold_left;
	bit held;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!held && accepted >= 40) begin
				held = 1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int p;
		logic [5:0] r, c;
		logic signed [15:0] v;
		for (int k = 0; k < VEC_DEPTH; k++) begin
			x_vec[k] = '0;
			y_acc[k] = '0;
		end

		// Directed: empty matrix, mismatch, zero value, unknown type, extremes, saturation.
		queue_req(coo_spmv_pkg::REQ_MUL, '0, '0, '0, '0, '0, 7'd0);
		queue_req(coo_spmv_pkg::REQ_MUL, '0, '0, '0, '0, '0, 7'd5);
		queue_req(coo_spmv_pkg::REQ_ADD, 6'd3, 6'd3, 16'sd0, '0, '0, '0);
		queue_req(coo_spmv_pkg::REQ_BAD, 6'h3F, 6'h3F, -16'sd1, 6'h3F, -16'sd1, 7'h7F);
		for (int k = 0; k < 3; k++) begin
			queue_req(coo_spmv_pkg::REQ_ADD, 6'd0, k[5:0], 16'sh7FFF, '0, '0, '0);
			queue_req(coo_spmv_pkg::REQ_ADD, 6'd1, k[5:0], -16'sh8000, '0, '0, '0);
			queue_req(coo_spmv_pkg::REQ_LOAD, '0, '0, '0, k[5:0], 16'sh7FFF, '0);
		end
		queue_req(coo_spmv_pkg::REQ_ADD, 6'd1, 6'd0, -16'sh8000, '0, '0, '0);
		queue_req(coo_spmv_pkg::REQ_MUL, '0, '0, '0, '0, '0, 7'd3);
		queue_req(coo_spmv_pkg::REQ_ADD, 6'h3F, 6'h3F, 16'sh7FFF, '0, '0, '0);
		queue_req(coo_spmv_pkg::REQ_LOAD, '0, '0, '0, 6'h3F, -16'sh8000, '0);
		queue_req(coo_spmv_pkg::REQ_ADD, 6'h3F, 6'h3F, -16'sh8000, '0, '0, '0);
		queue_req(coo_spmv_pkg::REQ_MUL, '0, '0, '0, '0, '0, 7'd64);

		// Random traffic, mostly table building with matching multiplies mixed in.
		for (int n = 0; n < 80; n++) begin
			p = $urandom_range(0, 99);
			if (p < 3) begin
				queue_req(coo_spmv_pkg::REQ_BAD, 6'($urandom), 6'($urandom), 16'($urandom),
					6'($urandom), 16'($urandom), 7'($urandom));
			end else if (p < 75) begin
				r = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
				c = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
				v = ($urandom_range(0, 19) == 0) ? 16'sd0 : rand_q88();
				queue_req(coo_spmv_pkg::REQ_ADD, r, c, v, 6'($urandom), 16'($urandom),
					7'($urandom));
			end else if (p < 88) begin
				queue_req(coo_spmv_pkg::REQ_LOAD, 6'($urandom), 6'($urandom), 16'($urandom),
					6'($urandom), rand_q88(), 7'($urandom));
			end else begin
				queue_req(coo_spmv_pkg::REQ_MUL, 6'($urandom), 6'($urandom), 16'($urandom),
					6'($urandom), 16'($urandom),
					($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'(gen_cols), n == 40);
			end
		end

		// Fill the table, then try new positions against a full table and an overwrite.
		for (int a = 0; a < VEC_DEPTH && gen_count < TABLE_DEPTH; a++)
			for (int b = 0; b < VEC_DEPTH && gen_count < TABLE_DEPTH; b++)
				if (!gen_seen[a][b])
					queue_req(coo_spmv_pkg::REQ_ADD, a[5:0], b[5:0], rand_q88(), '0, '0, '0);
		for (int k = 0; k < 4; k++)
			queue_req(coo_spmv_pkg::REQ_ADD, 6'($urandom), 6'($urandom), 16'sd77, '0, '0, '0);
		queue_req(coo_spmv_pkg::REQ_ADD, 6'h3F, 6'h3F, 16'sd1, '0, '0, '0);
		for (int k = 0; k < 6; k++) begin
			queue_req(coo_spmv_pkg::REQ_LOAD, '0, '0, '0, 6'($urandom), rand_q88(), '0);
			queue_req(coo_spmv_pkg::REQ_MUL, '0, '0, '0, '0, '0, 7'(gen_cols));
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_reqs.size() == 0 && !in_valid && expected_y.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_y.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
